/* rtl/dsac_pkg.sv */
package dsac_pkg;

   localparam int TABLE_SIZE_DEFAULT = 1048576;
   localparam int QUERY_W = 20;
   localparam int SUM_W = 23;
   localparam logic [SUM_W-1:0] SUM_MAX = 23'h7FFFFF;

   localparam int OP_W = 5;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_NOP       = 5'd0;
   localparam op_type OP_CLR_WRITE = 5'd1;
   localparam op_type OP_SV_SQUARE = 5'd2;
   localparam op_type OP_SV_RD_I   = 5'd3;
   localparam op_type OP_SV_TEST_I = 5'd4;
   localparam op_type OP_SV_NEXT_I = 5'd5;
   localparam op_type OP_SV_RD_J   = 5'd6;
   localparam op_type OP_SV_MARK_J = 5'd7;
   localparam op_type OP_IDLE      = 5'd8;
   localparam op_type OP_ZERO      = 5'd9;
   localparam op_type OP_FINIT_H   = 5'd10;
   localparam op_type OP_FINIT_S   = 5'd11;
   localparam op_type OP_FREAD     = 5'd12;
   localparam op_type OP_FGOT      = 5'd13;
   localparam op_type OP_FSTEP     = 5'd14;
   localparam op_type OP_FDIV      = 5'd15;
   localparam op_type OP_FCLOSE    = 5'd16;
   localparam op_type OP_QSUM      = 5'd17;
   localparam op_type OP_QAMIC     = 5'd18;
   localparam op_type OP_OUT       = 5'd19;

   typedef struct packed {
      logic clr_last;
      logic sq_done;
      logic rd_zero;
      logic j_done;
      logic accepted;
      logic q_bad;
      logic n_one;
      logic div_done;
      logic try_partner;
      logic out_free;
   } status_type;

endpackage

/* rtl/dsac_if.sv */
interface dsac_req_if;
   logic                          valid;
   logic                          ready;
   logic [dsac_pkg::QUERY_W-1:0]  query_number;

   modport source (output valid, output query_number, input ready);
   modport sink (input valid, input query_number, output ready);
endinterface

interface dsac_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dsac_pkg::SUM_W-1:0]  proper_divisor_sum;
   logic                        partner_in_range;
   logic                        is_amicable;

   modport source (output valid, output proper_divisor_sum, output partner_in_range,
                   output is_amicable, input ready);
   modport sink (input valid, input proper_divisor_sum, input partner_in_range,
                 input is_amicable, output ready);
endinterface

/* rtl/dsac_ram.sv */
module dsac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/dsac_div.sv */
module dsac_div #(
   parameter int W = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    rem_sh;
   logic [W:0]    diff;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = !diff[W];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/dsac_datapath.sv */
module dsac_datapath #(
   parameter int TABLE_SIZE = dsac_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dsac_pkg::op_type     op,
   output dsac_pkg::status_type status,
   dsac_req_if.sink             req_chan,
   dsac_rsp_if.source           rsp_chan
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int SW = AW + 3;
   localparam int IW = (AW + 1) / 2 + 1;
   localparam int JW = AW + 1;
   localparam int QW = dsac_pkg::QUERY_W;
   localparam int OW = dsac_pkg::SUM_W;
   localparam logic [31:0] SIZE_U = 32'(TABLE_SIZE);

   logic [AW-1:0]   c_ff, c_in;
   logic [IW-1:0]   i_ff, i_in;
   logic [2*IW-1:0] sq_ff, sq_in;
   logic [JW-1:0]   j_ff, j_in;
   logic [QW-1:0]   h_ff, h_in;
   logic [AW-1:0]   n_ff, n_in;
   logic [AW-1:0]   cur_p_ff, cur_p_in;
   logic [AW-1:0]   pw_ff, pw_in;
   logic [SW-1:0]   geo_ff, geo_in;
   logic [SW-1:0]   prod_ff, prod_in;
   logic [SW-1:0]   s_ff, s_in;
   logic            zero_ff, zero_in;
   logic            amic_ff, amic_in;
   logic            ovalid_ff, ovalid_in;
   logic [OW-1:0]   osum_ff, osum_in;
   logic            orange_ff, orange_in;
   logic            oamic_ff, oamic_in;

   logic            we;
   logic [AW-1:0]   waddr;
   logic [AW-1:0]   wdata;
   logic [AW-1:0]   raddr;
   logic [AW-1:0]   rd_data;
   logic [AW-1:0]   pf;
   logic            rd_zero;
   logic            in_range;
   logic            out_free;
   logic            accepted;
   logic            div_start;
   logic            div_done;
   logic [AW-1:0]   div_quo;
   logic [JW-1:0]   step2i;

   dsac_ram #(
      .WIDTH (AW),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd_data)
   );

   dsac_div #(
      .W (AW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (cur_p_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rd_zero   = rd_data == '0;
   assign pf        = rd_zero ? n_ff : rd_data;
   assign in_range  = 32'(s_ff) < SIZE_U;
   assign out_free  = !ovalid_ff || rsp_chan.ready;
   assign accepted  = req_chan.valid && req_chan.ready;
   assign div_start = op == dsac_pkg::OP_FSTEP;
   assign step2i    = JW'({i_ff, 1'b0});

   assign req_chan.ready = op == dsac_pkg::OP_IDLE;

   assign status.clr_last    = c_ff == AW'(TABLE_SIZE - 1);
   assign status.sq_done     = 32'(sq_ff) >= SIZE_U;
   assign status.rd_zero     = rd_zero;
   assign status.j_done      = 32'(j_ff) >= SIZE_U;
   assign status.accepted    = accepted;
   assign status.q_bad       = h_ff == '0 || 32'(h_ff) >= SIZE_U;
   assign status.n_one       = n_ff == AW'(1);
   assign status.div_done    = div_done;
   assign status.try_partner = in_range && s_ff != '0 && s_ff != SW'(h_ff);
   assign status.out_free    = out_free;

   always_comb begin
      c_in      = c_ff;
      i_in      = i_ff;
      sq_in     = sq_ff;
      j_in      = j_ff;
      h_in      = h_ff;
      n_in      = n_ff;
      cur_p_in  = cur_p_ff;
      pw_in     = pw_ff;
      geo_in    = geo_ff;
      prod_in   = prod_ff;
      s_in      = s_ff;
      zero_in   = zero_ff;
      amic_in   = amic_ff;
      ovalid_in = ovalid_ff;
      osum_in   = osum_ff;
      orange_in = orange_ff;
      oamic_in  = oamic_ff;
      we        = 1'b0;
      waddr     = c_ff;
      wdata     = '0;
      raddr     = n_ff;

      if (ovalid_ff && rsp_chan.ready) begin
         ovalid_in = 1'b0;
      end

      unique case (op)
         dsac_pkg::OP_CLR_WRITE: begin
            we    = 1'b1;
            waddr = c_ff;
            wdata = (!c_ff[0] && c_ff != '0) ? AW'(2) : '0;
            c_in  = c_ff + 1'b1;
         end
         dsac_pkg::OP_SV_SQUARE: begin
            sq_in = (2*IW)'(i_ff) * (2*IW)'(i_ff);
         end
         dsac_pkg::OP_SV_RD_I: begin
            raddr = AW'(i_ff);
         end
         dsac_pkg::OP_SV_TEST_I: begin
            if (rd_zero) begin
               j_in = JW'(sq_ff);
            end else begin
               i_in = i_ff + IW'(2);
            end
         end
         dsac_pkg::OP_SV_NEXT_I: begin
            i_in = i_ff + IW'(2);
         end
         dsac_pkg::OP_SV_RD_J: begin
            raddr = AW'(j_ff);
         end
         dsac_pkg::OP_SV_MARK_J: begin
            we    = rd_zero;
            waddr = AW'(j_ff);
            wdata = AW'(i_ff);
            j_in  = j_ff + step2i;
         end
         dsac_pkg::OP_IDLE: begin
            if (accepted) begin
               h_in = req_chan.query_number;
            end
         end
         dsac_pkg::OP_ZERO: begin
            zero_in = 1'b1;
            amic_in = 1'b0;
         end
         dsac_pkg::OP_FINIT_H, dsac_pkg::OP_FINIT_S: begin
            n_in     = (op == dsac_pkg::OP_FINIT_H) ? AW'(h_ff) : AW'(s_ff);
            prod_in  = SW'(1);
            cur_p_in = '0;
            pw_in    = AW'(1);
            geo_in   = SW'(1);
         end
         dsac_pkg::OP_FREAD: begin
            raddr = n_ff;
         end
         dsac_pkg::OP_FGOT: begin
            if (pf == cur_p_ff) begin
               pw_in = pw_ff * pf;
            end else begin
               prod_in  = prod_ff * geo_ff;
               cur_p_in = pf;
               pw_in    = pf;
               geo_in   = SW'(1);
            end
         end
         dsac_pkg::OP_FSTEP: begin
            geo_in = geo_ff + SW'(pw_ff);
         end
         dsac_pkg::OP_FDIV: begin
            if (div_done) begin
               n_in = div_quo;
            end
         end
         dsac_pkg::OP_FCLOSE: begin
            prod_in = prod_ff * geo_ff;
         end
         dsac_pkg::OP_QSUM: begin
            s_in    = prod_ff - SW'(h_ff);
            zero_in = 1'b0;
            amic_in = 1'b0;
         end
         dsac_pkg::OP_QAMIC: begin
            amic_in = (prod_ff - s_ff) == SW'(h_ff);
         end
         dsac_pkg::OP_OUT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               if (zero_ff) begin
                  osum_in = '0;
               end else if (32'(s_ff) > 32'(dsac_pkg::SUM_MAX)) begin
                  osum_in = dsac_pkg::SUM_MAX;
               end else begin
                  osum_in = OW'(s_ff);
               end
               orange_in = !zero_ff && in_range;
               oamic_in  = amic_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff      <= '0;
         i_ff      <= IW'(3);
         ovalid_ff <= 1'b0;
      end else begin
         c_ff      <= c_in;
         i_ff      <= i_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      j_ff     <= j_in;
      h_ff     <= h_in;
      n_ff     <= n_in;
      cur_p_ff <= cur_p_in;
      pw_ff    <= pw_in;
      geo_ff   <= geo_in;
      prod_ff  <= prod_in;
      s_ff     <= s_in;
      zero_ff  <= zero_in;
      amic_ff  <= amic_in;
      osum_ff  <= osum_in;
      orange_ff <= orange_in;
      oamic_ff <= oamic_in;
   end

   assign rsp_chan.valid              = ovalid_ff;
   assign rsp_chan.proper_divisor_sum = osum_ff;
   assign rsp_chan.partner_in_range   = orange_ff;
   assign rsp_chan.is_amicable        = oamic_ff;

   a_div_exact: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((2*AW)'(div_quo) * (2*AW)'(cur_p_ff)) == (2*AW)'(n_ff))
      else $error("factor does not divide the remaining number");

   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      op == dsac_pkg::OP_FGOT |-> pf >= AW'(2) && pf <= n_ff)
      else $error("table lookup gave an impossible factor");

   a_lookup_above_one: assert property (@(posedge clock) disable iff (reset)
      op == dsac_pkg::OP_FREAD |-> n_ff > AW'(1))
      else $error("lookup issued for a fully factored number");

   a_mark_in_table: assert property (@(posedge clock) disable iff (reset)
      op == dsac_pkg::OP_SV_MARK_J |-> 32'(j_ff) < SIZE_U)
      else $error("sieve mark beyond the table");

   a_amicable_in_range: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && oamic_ff |-> orange_ff && osum_ff != '0)
      else $error("amicable flag without an in-range nonzero partner");

endmodule

/* rtl/dsac_ctrl.sv */
module dsac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  dsac_pkg::status_type status,
   output dsac_pkg::op_type     op
);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_SQ    = 4'd1;
   localparam logic [3:0] S_ICHK  = 4'd2;
   localparam logic [3:0] S_ITEST = 4'd3;
   localparam logic [3:0] S_JRD   = 4'd4;
   localparam logic [3:0] S_JMARK = 4'd5;
   localparam logic [3:0] S_IDLE  = 4'd6;
   localparam logic [3:0] S_QCHK  = 4'd7;
   localparam logic [3:0] S_FLOOK = 4'd8;
   localparam logic [3:0] S_FGOT  = 4'd9;
   localparam logic [3:0] S_FSTEP = 4'd10;
   localparam logic [3:0] S_FDIV  = 4'd11;
   localparam logic [3:0] S_FEND  = 4'd12;
   localparam logic [3:0] S_QTRY  = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       partner_ff, partner_in;

   always_comb begin
      state_in   = state_ff;
      partner_in = partner_ff;
      op         = dsac_pkg::OP_NOP;
      unique case (state_ff)
         S_CLR: begin
            op = dsac_pkg::OP_CLR_WRITE;
            if (status.clr_last) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            op       = dsac_pkg::OP_SV_SQUARE;
            state_in = S_ICHK;
         end
         S_ICHK: begin
            if (status.sq_done) begin
               state_in = S_IDLE;
            end else begin
               op       = dsac_pkg::OP_SV_RD_I;
               state_in = S_ITEST;
            end
         end
         S_ITEST: begin
            op       = dsac_pkg::OP_SV_TEST_I;
            state_in = status.rd_zero ? S_JRD : S_SQ;
         end
         S_JRD: begin
            if (status.j_done) begin
               op       = dsac_pkg::OP_SV_NEXT_I;
               state_in = S_SQ;
            end else begin
               op       = dsac_pkg::OP_SV_RD_J;
               state_in = S_JMARK;
            end
         end
         S_JMARK: begin
            op       = dsac_pkg::OP_SV_MARK_J;
            state_in = S_JRD;
         end
         S_IDLE: begin
            op = dsac_pkg::OP_IDLE;
            if (status.accepted) begin
               state_in = S_QCHK;
            end
         end
         S_QCHK: begin
            if (status.q_bad) begin
               op       = dsac_pkg::OP_ZERO;
               state_in = S_OUT;
            end else begin
               op         = dsac_pkg::OP_FINIT_H;
               partner_in = 1'b0;
               state_in   = S_FLOOK;
            end
         end
         S_FLOOK: begin
            if (status.n_one) begin
               op       = dsac_pkg::OP_FCLOSE;
               state_in = S_FEND;
            end else begin
               op       = dsac_pkg::OP_FREAD;
               state_in = S_FGOT;
            end
         end
         S_FGOT: begin
            op       = dsac_pkg::OP_FGOT;
            state_in = S_FSTEP;
         end
         S_FSTEP: begin
            op       = dsac_pkg::OP_FSTEP;
            state_in = S_FDIV;
         end
         S_FDIV: begin
            op = dsac_pkg::OP_FDIV;
            if (status.div_done) begin
               state_in = S_FLOOK;
            end
         end
         S_FEND: begin
            if (partner_ff) begin
               op       = dsac_pkg::OP_QAMIC;
               state_in = S_OUT;
            end else begin
               op       = dsac_pkg::OP_QSUM;
               state_in = S_QTRY;
            end
         end
         S_QTRY: begin
            if (status.try_partner) begin
               op         = dsac_pkg::OP_FINIT_S;
               partner_in = 1'b1;
               state_in   = S_FLOOK;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            op = dsac_pkg::OP_OUT;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         partner_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         partner_ff <= partner_in;
      end
   end

endmodule

/* rtl/divisor_sum_amicable_check.sv */
// Proper divisor sum and amicable check. After reset the block builds a smallest prime
// factor table in a RAM of TABLE_SIZE entries: a clearing pass over every entry that
// also sets every nonzero even entry to 2, then an odd-stride sieve for primes up to the
// square root that marks each odd multiple it visits that is still unset; no query
// transaction is taken during either pass. A query is then factored by table lookup and
// exact division in a bit-serial divider, one prime factor at a time, counted with
// multiplicity, and the partner is factored the same way when it is nonzero, lies inside
// the table and differs from the query. A finished result sits in an output register, so
// the next query transaction is taken while it waits. Queries of zero or at or beyond the
// table return all zeros; a sum beyond the table clears the in-range and amicable flags;
// the sum output saturates at 8388607.
module divisor_sum_amicable_check #(
   parameter int TABLE_SIZE = dsac_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dsac_req_if.sink   req_chan,
   dsac_rsp_if.source rsp_chan
);

   dsac_pkg::op_type     op;
   dsac_pkg::status_type status;

   dsac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   dsac_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

/* sim/divisor_sum_amicable_check_tb.sv */
`timescale 1ns / 1ps

module divisor_sum_amicable_check_tb;

   localparam int TABLE_SZ = dsac_pkg::TABLE_SIZE_DEFAULT;
   localparam int RANDOM_QUERIES = 1400;
   localparam int CALM_TAIL = 150;
   localparam int DRAIN_CYCLES = 1100;
   localparam int AMICABLE_COUNT = 24;
   localparam int DIRECTED_COUNT = 25;

   typedef struct {
      logic [dsac_pkg::SUM_W-1:0] proper_divisor_sum;
      logic                       partner_in_range;
      logic                       is_amicable;
   } divsum_result_type;

   logic clock;
   logic reset;

   dsac_req_if req_if ();
   dsac_rsp_if rsp_if ();

   divisor_sum_amicable_check #(
      .TABLE_SIZE(TABLE_SZ)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   int unsigned smallest_factor [TABLE_SZ];
   int unsigned amicable_members [AMICABLE_COUNT] = '{
      220, 284, 1184, 1210, 2620, 2924, 5020, 5564, 6232, 6368, 10744, 10856,
      12285, 14595, 17296, 18416, 63020, 76084, 66928, 66992, 67095, 71145,
      100485, 124155
   };
   int unsigned directed_queries [DIRECTED_COUNT] = '{
      0, 1, 2, 3, 4, 6, 28, 496, 8128, 12, 945, 220, 284, 1184, 12285, 100485,
      720720, 524288, 524287, 786432, 655360, 1048575, 1048574, 1048573, 997920
   };

   logic [dsac_pkg::QUERY_W-1:0] query_queue [$];
   divsum_result_type            expected_sums [$];

   int  queries_sent = 0;
   int  results_seen = 0;
   int  mismatch_count = 0;
   int  total_queries;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  req_taken = 0;
   int  req_handled = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("divisor_sum_amicable_check regression: fail");
      $finish;
   end

   function automatic longint unsigned proper_sum_of(input longint unsigned h);
      longint unsigned prod = 1;
      longint unsigned n = h;
      longint unsigned pf;
      longint unsigned geo;
      longint unsigned pw;
      while (n > 1) begin
         pf = 64'(smallest_factor[n]);
         if (pf < 2) break;
         geo = 1;
         pw = 1;
         while (n % pf == 0) begin
            n = n / pf;
            pw = pw * pf;
            geo = geo + pw;
         end
         prod = prod * geo;
      end
      return prod - h;
   endfunction

   function automatic divsum_result_type predict_divsum(
      input logic [dsac_pkg::QUERY_W-1:0] query);
      divsum_result_type res;
      longint unsigned   s;
      res.proper_divisor_sum = '0;
      res.partner_in_range = 1'b0;
      res.is_amicable = 1'b0;
      if (query == 0 || query >= TABLE_SZ) return res;
      s = proper_sum_of(64'(query));
      if (s < TABLE_SZ) begin
         res.partner_in_range = 1'b1;
         if (s != 0 && s != 64'(query) && proper_sum_of(s) == 64'(query))
            res.is_amicable = 1'b1;
      end
      res.proper_divisor_sum = (s > 64'(dsac_pkg::SUM_MAX)) ? dsac_pkg::SUM_MAX
                                                            : s[dsac_pkg::SUM_W-1:0];
      return res;
   endfunction

   function automatic logic [dsac_pkg::QUERY_W-1:0] random_query();
      int unsigned pick;
      int unsigned v;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         v = $urandom_range(1, TABLE_SZ - 1);
      end else if (pick < 75) begin
         v = amicable_members[$urandom_range(0, AMICABLE_COUNT - 1)];
      end else if (pick < 85) begin
         v = $urandom_range(1, 400);
      end else if (pick < 95) begin
         v = ($urandom_range(1, 15) << $urandom_range(0, 16)) & (TABLE_SZ - 1);
         if (v == 0) v = 1;
      end else begin
         v = $urandom_range(TABLE_SZ - 8192, TABLE_SZ - 1);
      end
      return v[dsac_pkg::QUERY_W-1:0];
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         expected_sums.push_back(predict_divsum(req_if.query_number));
         req_taken++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken != req_handled) begin
         req_handled = req_taken;
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (query_queue.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.query_number <= query_queue.pop_front();
            queries_sent++;
            if (queries_sent < total_queries - CALM_TAIL && $urandom_range(0, 5) == 0)
               req_gap = $urandom_range(1, 8);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (results_seen < total_queries - CALM_TAIL && $urandom_range(0, 5) == 0)
            rsp_gap = $urandom_range(1, 8);
      end
   end

   always @(posedge clock) begin
      divsum_result_type exp_res;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (expected_sums.size() == 0) begin
            $error("unexpected transaction: proper_divisor_sum %0d", rsp_if.proper_divisor_sum);
            mismatch_count++;
         end else begin
            exp_res = expected_sums.pop_front();
            if (rsp_if.proper_divisor_sum !== exp_res.proper_divisor_sum) begin
               $error("proper_divisor_sum expected %0d got %0d",
                      exp_res.proper_divisor_sum, rsp_if.proper_divisor_sum);
               mismatch_count++;
            end
            if (rsp_if.partner_in_range !== exp_res.partner_in_range) begin
               $error("partner_in_range expected %0d got %0d",
                      exp_res.partner_in_range, rsp_if.partner_in_range);
               mismatch_count++;
            end
            if (rsp_if.is_amicable !== exp_res.is_amicable) begin
               $error("is_amicable expected %0d got %0d",
                      exp_res.is_amicable, rsp_if.is_amicable);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      longint unsigned i;
      longint unsigned j;
      reset = 1'b1;
      total_queries = DIRECTED_COUNT + RANDOM_QUERIES;

      // smallest prime factor of each index
      for (i = 0; i < TABLE_SZ; i++)
         smallest_factor[i] = (i % 2 == 0 && i > 0) ? 32'd2 : 32'd0;
      for (i = 3; i < TABLE_SZ; i += 2) begin
         if (smallest_factor[i] == 0) begin
            smallest_factor[i] = 32'(i);
            for (j = i * i; j < TABLE_SZ; j += 2 * i)
               if (smallest_factor[j] == 0) smallest_factor[j] = 32'(i);
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_queries[k])
         query_queue.push_back(directed_queries[k][dsac_pkg::QUERY_W-1:0]);
      repeat (RANDOM_QUERIES / 2) query_queue.push_back(random_query());

      // hold off until the block has drained
      while (query_queue.size() > 0 || req_if.valid || expected_sums.size() > 0)
         @(posedge clock);

      repeat (RANDOM_QUERIES - RANDOM_QUERIES / 2) query_queue.push_back(random_query());

      while (query_queue.size() > 0 || req_if.valid || expected_sums.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_sums.size() == 0)
         $display("divisor_sum_amicable_check regression: pass");
      else
         $display("divisor_sum_amicable_check regression: fail");
      $finish;
   end

endmodule
